FILE: hdl/tfc_pkg.sv
// shared types, constants and helper functions of the temporal flicker clamp
`timescale 1ns / 1ps

package tfc_pkg;

  localparam int SAMPLE_BITS    = 8;
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 2;
  localparam int STRENGTH_BITS  = 2;

  typedef logic [SAMPLE_BITS-1:0] sample_t;

  // register indexes on the configuration port
  localparam logic [CFG_INDEX_BITS-1:0] CFG_STRENGTH   = CFG_INDEX_BITS'(0);
  localparam logic [CFG_INDEX_BITS-1:0] CFG_AGGRESSIVE = CFG_INDEX_BITS'(1);

  localparam logic [STRENGTH_BITS-1:0] STRENGTH_RESET = STRENGTH_BITS'(2);
  localparam logic [STRENGTH_BITS-1:0] STRENGTH_TWO   = STRENGTH_BITS'(2);
  localparam logic [STRENGTH_BITS-1:0] STRENGTH_THREE = STRENGTH_BITS'(3);

  typedef struct packed {
    logic [STRENGTH_BITS-1:0] strength;
    logic                     aggressive;
  } cfg_t;

  // upward and downward difference bounds
  typedef struct packed {
    sample_t up;
    sample_t dn;
  } bound_t;

  // one frame sample pulls the signed bounds toward the current sample
  function automatic bound_t signed_bound(input sample_t x, input sample_t c,
                                          input bound_t prev);
    bound_t res;
    res = prev;
    if (x >= c) begin
      res.dn = '0;
      if ((x - c) < prev.up) res.up = x - c;
    end else begin
      res.up = '0;
      if ((c - x) < prev.dn) res.dn = c - x;
    end
    return res;
  endfunction

  function automatic sample_t abs_diff(input sample_t a, input sample_t b);
    return (a < b) ? (b - a) : (a - b);
  endfunction

  function automatic sample_t umin(input sample_t a, input sample_t b);
    return (a < b) ? a : b;
  endfunction

  function automatic sample_t umax(input sample_t a, input sample_t b);
    return (a > b) ? a : b;
  endfunction

endpackage

FILE: hdl/temporal_flicker_clamp_pixel.sv
// top level of the temporal flicker clamp: registers, handshake and config
`timescale 1ns / 1ps

// usage
// - pixel channel (pix_valid / pix_stall): one beat carries the current sample
//   and the co-located samples of three earlier and three later frames
// - result channel (res_valid / res_stall): one beat carries the filtered sample
// - config channel (cfg_valid / cfg_ready): index 0 strength, index 1 aggressive;
//   cfg_ready is always high, other indexes are dropped; write only when idle
// - flow: an accepted pixel goes into the input register, then its result into
//   the result register, from which its result beat is taken; one pixel per
//   clock sustained while res_stall stays low, set by the single logic stage between
//   the input register and the result register
// - no state between pixels, so pixels flow back to back
// - stall: while res_stall holds a waiting result, one more pixel is taken into
//   the input register, then pix_stall rises until the result register frees
// - reset (rst, synchronous): both pipeline stages empty, strength 2,
//   aggressive 0

module temporal_flicker_clamp_pixel import tfc_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,

  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,

  input  logic                      pix_valid,
  output logic                      pix_stall,
  input  sample_t                   cur_sample,
  input  sample_t                   prev_one,
  input  sample_t                   prev_two,
  input  sample_t                   prev_three,
  input  sample_t                   next_one,
  input  sample_t                   next_two,
  input  sample_t                   next_three,

  output logic                      res_valid,
  input  logic                      res_stall,
  output sample_t                   out_sample
);

  cfg_t    cfg;

  // input register
  logic    s1_valid;
  sample_t s1_cur, s1_p1, s1_p2, s1_p3, s1_n1, s1_n2, s1_n3;

  logic    advance;
  logic    take_pix;
  bound_t  bnd;
  sample_t filt;

  // config registers, always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.strength   <= STRENGTH_RESET;
      cfg.aggressive <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_STRENGTH:   cfg.strength   <= cfg_data[STRENGTH_BITS-1:0];
        CFG_AGGRESSIVE: cfg.aggressive <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // result register moves when empty or taken
  assign advance   = !res_valid || !res_stall;
  assign pix_stall = s1_valid && !advance;
  assign take_pix  = pix_valid && !pix_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!pix_stall) begin
      s1_valid <= pix_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take_pix) begin
      s1_cur <= cur_sample;
      s1_p1  <= prev_one;
      s1_p2  <= prev_two;
      s1_p3  <= prev_three;
      s1_n1  <= next_one;
      s1_n2  <= next_two;
      s1_n3  <= next_three;
    end
  end

  tfc_bound u_bound (
    .cfg        (cfg),
    .cur_sample (s1_cur),
    .prev_two   (s1_p2),
    .prev_three (s1_p3),
    .next_two   (s1_n2),
    .next_three (s1_n3),
    .bnd        (bnd)
  );

  tfc_blend u_blend (
    .cur_sample (s1_cur),
    .prev_one   (s1_p1),
    .next_one   (s1_n1),
    .bnd        (bnd),
    .out_sample (filt)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      out_sample <= filt;
    end
  end

  // a held input stage keeps its pixel
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !advance) |=> (s1_valid && $stable(s1_cur) && $stable(s1_p1)))
    else $error("input stage lost its pixel while the result was held");

  // an accepted pixel lands in the input stage
  a_take_fills: assert property (@(posedge clk) disable iff (rst)
    take_pix |=> s1_valid)
    else $error("accepted pixel did not reach the input stage");

  // a pixel leaving the input stage becomes a result
  a_s1_to_res: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && advance) |=> res_valid)
    else $error("pixel dropped between input stage and result register");

  // plain mode bounds both sides by the same difference
  a_plain_bound: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !cfg.aggressive) |-> (bnd.up == bnd.dn))
    else $error("plain mode bounds differ");

endmodule

FILE: hdl/tfc_bound.sv
// temporal difference bound from the outer frame samples
`timescale 1ns / 1ps

module tfc_bound import tfc_pkg::*; (
  input  cfg_t    cfg,
  input  sample_t cur_sample,
  input  sample_t prev_two,
  input  sample_t prev_three,
  input  sample_t next_two,
  input  sample_t next_three,
  output bound_t  bnd
);

  logic   use_two;
  logic   use_three;
  bound_t sb0, sb1, sb2, sb3;
  bound_t sb_final;
  sample_t d;

  assign use_two   = (cfg.strength == STRENGTH_TWO) || (cfg.strength == STRENGTH_THREE);
  assign use_three = (cfg.strength == STRENGTH_THREE);

  // signed chain, starting from an open bound
  always_comb begin
    sb0 = signed_bound(prev_two, cur_sample, '{up: '1, dn: '1});
    sb1 = use_two   ? signed_bound(next_two, cur_sample, sb0) : sb0;
    sb2 = use_three ? signed_bound(prev_three, cur_sample, sb1) : sb1;
    sb3 = use_three ? signed_bound(next_three, cur_sample, sb2) : sb2;
    sb_final = sb3;
  end

  // smallest absolute difference
  always_comb begin
    d = abs_diff(cur_sample, prev_two);
    if (use_two) d = umin(d, abs_diff(cur_sample, next_two));
    if (use_three) begin
      d = umin(d, abs_diff(cur_sample, prev_three));
      d = umin(d, abs_diff(cur_sample, next_three));
    end
  end

  always_comb begin
    if (cfg.aggressive) begin
      bnd = sb_final;
    end else begin
      bnd.up = d;
      bnd.dn = d;
    end
  end

endmodule

FILE: hdl/tfc_blend.sv
// blend of current and adjacent samples, clamped to the widened limits
`timescale 1ns / 1ps

module tfc_blend import tfc_pkg::*; (
  input  sample_t cur_sample,
  input  sample_t prev_one,
  input  sample_t next_one,
  input  bound_t  bnd,
  output sample_t out_sample
);

  logic [SAMPLE_BITS:0]          pair_sum;
  sample_t                       pair_mean;
  sample_t                       t;
  logic [SAMPLE_BITS:0]          blend_sum;
  sample_t                       avg;
  sample_t                       adj_min;
  sample_t                       adj_max;
  logic signed [SAMPLE_BITS+1:0] low_edge;
  logic signed [SAMPLE_BITS+1:0] cur_s;
  logic [SAMPLE_BITS:0]          high_edge;
  sample_t                       hi;
  sample_t                       lo;

  assign pair_sum  = {1'b0, prev_one} + {1'b0, next_one} + (SAMPLE_BITS+1)'(1);
  assign pair_mean = pair_sum[SAMPLE_BITS:1];
  assign t         = (pair_mean == '0) ? '0 : pair_mean - SAMPLE_BITS'(1);
  assign blend_sum = {1'b0, t} + {1'b0, cur_sample} + (SAMPLE_BITS+1)'(1);
  assign avg       = blend_sum[SAMPLE_BITS:1];

  assign adj_min = umin(prev_one, next_one);
  assign adj_max = umax(prev_one, next_one);

  // min side may go below zero before it meets the current sample
  assign low_edge  = $signed({2'b00, adj_min}) - $signed({2'b00, bnd.up});
  assign cur_s     = $signed({2'b00, cur_sample});
  assign hi        = (low_edge > cur_s) ? low_edge[SAMPLE_BITS-1:0] : cur_sample;

  assign high_edge = {1'b0, adj_max} + {1'b0, bnd.dn};
  assign lo        = (high_edge < {1'b0, cur_sample}) ? high_edge[SAMPLE_BITS-1:0]
                                                      : cur_sample;

  assign out_sample = umin(umax(avg, lo), hi);

endmodule

FILE: dv/tb_temporal_flicker_clamp_pixel.sv
// self-checking testbench of the temporal flicker clamp pixel block
`timescale 1ns / 1ps

module tb_temporal_flicker_clamp_pixel;
  import tfc_pkg::*;

  localparam int NUM_PHASES      = 8;
  localparam int CORNERS         = 12;
  localparam int CORNERS_PER_SET = 3;
  localparam int RANDOM_PER_SET  = 60;
  localparam int SETTLE_CYCLES   = 4;     // input and result register plus margin
  localparam int QUIET_LIMIT     = 2000;  // cycles without any beat
  localparam int HOLD_OFF_AFTER  = 150;   // pixels taken before the long stall
  localparam int HOLD_OFF_CYCLES = 60;

  // indexes the block decodes to nothing, writes there must be dropped
  localparam logic [CFG_INDEX_BITS-1:0] CFG_SPARE_LO = CFG_INDEX_BITS'(2);
  localparam logic [CFG_INDEX_BITS-1:0] CFG_SPARE_HI = CFG_INDEX_BITS'(3);

  // register settings per phase; phase 0 runs on the reset values and
  // aggressive data 2 checks that only bit 0 counts
  localparam logic [CFG_DATA_BITS-1:0] PHASE_STRENGTH [NUM_PHASES] =
    '{2'd2, 2'd1, 2'd3, 2'd0, 2'd1, 2'd2, 2'd3, 2'd0};
  localparam logic [CFG_DATA_BITS-1:0] PHASE_AGGRESSIVE [NUM_PHASES] =
    '{2'd0, 2'd0, 2'd0, 2'd2, 2'd1, 2'd1, 2'd1, 2'd1};

  typedef enum int {STALL_NONE, STALL_COIN, STALL_EVERY_THIRD, STALL_HEAVY} stall_mode_t;

  // one pixel position across seven frames
  typedef struct {
    sample_t cur;
    sample_t p1;
    sample_t p2;
    sample_t p3;
    sample_t n1;
    sample_t n2;
    sample_t n3;
  } pixel_t;

  // mirrors the registers, predicts each filtered sample and checks the results
  class clamp_scoreboard;
    logic [STRENGTH_BITS-1:0] strength;
    logic                     aggressive;
    sample_t                  expected_q[$];
    int                       checked;
    int                       mismatches;

    function new();
      strength   = STRENGTH_RESET;
      aggressive = 1'b0;
      checked    = 0;
      mismatches = 0;
    endfunction

    function void write_register(logic [CFG_INDEX_BITS-1:0] index,
                                 logic [CFG_DATA_BITS-1:0] data);
      case (index)
        CFG_STRENGTH:   strength = data[STRENGTH_BITS-1:0];
        CFG_AGGRESSIVE: aggressive = data[0];
        default: ;
      endcase
    endfunction

    function int gap(int a, int b);
      return (a > b) ? a - b : b - a;
    endfunction

    // a frame sample on one side of cur zeroes the bound of the other side
    function void pull_bound(int x, int c, inout int up, inout int dn);
      if (x >= c) begin
        dn = 0;
        if (x - c < up) up = x - c;
      end else begin
        up = 0;
        if (c - x < dn) dn = c - x;
      end
    endfunction

    function sample_t clamp_pixel(pixel_t px);
      int c, p1, p2, p3, n1, n2, n3;
      int up, dn, d, t, avg, lo, hi;
      c  = px.cur;
      p1 = px.p1;
      p2 = px.p2;
      p3 = px.p3;
      n1 = px.n1;
      n2 = px.n2;
      n3 = px.n3;
      // strength 0 falls through both tests and acts as strength 1
      if (aggressive) begin
        up = p2 - c;
        dn = 0;
        if (up < 0) begin
          dn = -up;
          up = 0;
        end
        if (strength >= STRENGTH_TWO) pull_bound(n2, c, up, dn);
        if (strength >= STRENGTH_THREE) begin
          pull_bound(p3, c, up, dn);
          pull_bound(n3, c, up, dn);
        end
      end else begin
        d = gap(c, p2);
        if (strength >= STRENGTH_TWO && gap(c, n2) < d) d = gap(c, n2);
        if (strength >= STRENGTH_THREE) begin
          if (gap(c, p3) < d) d = gap(c, p3);
          if (gap(c, n3) < d) d = gap(c, n3);
        end
        up = d;
        dn = d;
      end
      t = (p1 + n1 + 1) / 2 - 1;
      if (t < 0) t = 0;
      avg = (t + c + 1) / 2;
      hi = ((p1 < n1) ? p1 : n1) - up;
      if (hi < c) hi = c;
      lo = ((p1 > n1) ? p1 : n1) + dn;
      if (lo > c) lo = c;
      if (avg < lo) avg = lo;
      if (avg > hi) avg = hi;
      return sample_t'(avg);
    endfunction

    function void note_pixel(pixel_t px);
      expected_q.push_back(clamp_pixel(px));
    endfunction

    function void check_result(sample_t got);
      sample_t want;
      if (expected_q.size() == 0) begin
        $error("out_sample: beat with no pixel pending, actual %0d", got);
        mismatches++;
      end else begin
        want = expected_q.pop_front();
        checked++;
        if (got !== want) begin
          $error("out_sample: expected %0d, actual %0d", want, got);
          mismatches++;
        end
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0]  cfg_data = '0;
  logic                      pix_valid = 1'b0;
  logic                      pix_stall;
  sample_t                   cur_sample = '0;
  sample_t                   prev_one = '0;
  sample_t                   prev_two = '0;
  sample_t                   prev_three = '0;
  sample_t                   next_one = '0;
  sample_t                   next_two = '0;
  sample_t                   next_three = '0;
  logic                      res_valid;
  logic                      res_stall = 1'b0;
  sample_t                   out_sample;

  clamp_scoreboard sb;
  int              pixels_accepted = 0;
  int              burst_left = 0;

  temporal_flicker_clamp_pixel u_top (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .pix_valid  (pix_valid),
    .pix_stall  (pix_stall),
    .cur_sample (cur_sample),
    .prev_one   (prev_one),
    .prev_two   (prev_two),
    .prev_three (prev_three),
    .next_one   (next_one),
    .next_two   (next_two),
    .next_three (next_three),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .out_sample (out_sample)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // result side: every beat taken is checked against the oldest prediction
  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall) sb.check_result(out_sample);
  end

  // sample near a base value, clipped into range
  function automatic sample_t near_sample(int base, int span);
    int v;
    v = base + int'($urandom_range(0, 2 * span)) - span;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return sample_t'(v);
  endfunction

  // mostly realistic content: quiet areas, one-sided motion, single-frame
  // spikes on the adjacent frames; the rest fully random
  function automatic pixel_t random_pixel();
    pixel_t px;
    int     c;
    int     span;
    c    = $urandom_range(0, 255);
    span = $urandom_range(1, 16);
    px.cur = sample_t'(c);
    case ($urandom_range(0, 3))
      0: begin
        px.p1 = sample_t'($urandom);
        px.p2 = sample_t'($urandom);
        px.p3 = sample_t'($urandom);
        px.n1 = sample_t'($urandom);
        px.n2 = sample_t'($urandom);
        px.n3 = sample_t'($urandom);
      end
      1: begin
        px.p1 = near_sample(c, span); px.p2 = near_sample(c, span);
        px.p3 = near_sample(c, span); px.n1 = near_sample(c, span);
        px.n2 = near_sample(c, span); px.n3 = near_sample(c, span);
      end
      2: begin
        // every neighbor on one side of cur
        if ($urandom_range(0, 1) == 1) begin
          px.p1 = sample_t'($urandom_range(c, 255));
          px.p2 = sample_t'($urandom_range(c, 255));
          px.p3 = sample_t'($urandom_range(c, 255));
          px.n1 = sample_t'($urandom_range(c, 255));
          px.n2 = sample_t'($urandom_range(c, 255));
          px.n3 = sample_t'($urandom_range(c, 255));
        end else begin
          px.p1 = sample_t'($urandom_range(0, c));
          px.p2 = sample_t'($urandom_range(0, c));
          px.p3 = sample_t'($urandom_range(0, c));
          px.n1 = sample_t'($urandom_range(0, c));
          px.n2 = sample_t'($urandom_range(0, c));
          px.n3 = sample_t'($urandom_range(0, c));
        end
      end
      default: begin
        // flicker: far adjacent frames, outer frames close to cur
        px.p1 = sample_t'($urandom);
        px.n1 = sample_t'($urandom);
        px.p2 = near_sample(c, span); px.p3 = near_sample(c, span);
        px.n2 = near_sample(c, span); px.n3 = near_sample(c, span);
      end
    endcase
    return px;
  endfunction

  // holds valid high across writes; the caller lowers it after the last one
  task automatic write_register(input logic [CFG_INDEX_BITS-1:0] index,
                                input logic [CFG_DATA_BITS-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_register(index, data);
  endtask

  // offers one pixel and waits for its beat; bursts end with a random gap,
  // the last pixel of a phase just drops valid
  task automatic offer_pixel(input pixel_t px, input bit last);
    pix_valid  <= 1'b1;
    cur_sample <= px.cur;
    prev_one   <= px.p1;
    prev_two   <= px.p2;
    prev_three <= px.p3;
    next_one   <= px.n1;
    next_two   <= px.n2;
    next_three <= px.n3;
    @(posedge clk);
    while (pix_stall) @(posedge clk);
    sb.note_pixel(px);
    pixels_accepted++;
    if (last) begin
      pix_valid <= 1'b0;
    end else if (burst_left == 0) begin
      pix_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      // long bursts now and then give stretches with no sender idling
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                 : $urandom_range(0, 8);
    end else begin
      burst_left--;
    end
  endtask

  // waits until every pixel in flight has come out
  task automatic wait_drained();
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // receiver stall pattern, plus one long hold-off that fills the pipeline
  // while the sender keeps offering
  initial begin : result_stall_pattern
    stall_mode_t mode;
    int          span;
    int          tick;
    bit          held_off;
    held_off = 1'b0;
    tick     = 0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (!held_off && pixels_accepted >= HOLD_OFF_AFTER) begin
        res_stall <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        held_off = 1'b1;
      end else begin
        mode = stall_mode_t'($urandom_range(0, 3));
        span = $urandom_range(8, 48);
        repeat (span) begin
          tick++;
          case (mode)
            STALL_NONE:        res_stall <= 1'b0;
            STALL_COIN:        res_stall <= ($urandom_range(0, 1) == 1);
            STALL_EVERY_THIRD: res_stall <= (tick % 3 == 0);
            default:           res_stall <= ($urandom_range(0, 3) != 0);
          endcase
          @(posedge clk);
        end
      end
    end
  end

  // ends the run when no beat moves on any channel for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst || (pix_valid && !pix_stall) || (res_valid && !res_stall) ||
          (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("timeout: no beat for %0d cycles, %0d results pending",
             QUIET_LIMIT, sb.pending());
    $display("Some tests failed");
    $finish;
  end

  initial begin : stimulus
    pixel_t corner_px [CORNERS];
    int     directed;
    bit     failed;

    sb = new();
    directed = 0;

    // extremes, alternating bit patterns and the special cases
    corner_px[0]  = '{8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0};
    corner_px[1]  = '{8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255};
    corner_px[2]  = '{8'd0,   8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255};
    corner_px[3]  = '{8'd255, 8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0};
    // outer frames on both sides of cur: signed bounds both forced to zero
    corner_px[4]  = '{8'd128, 8'd0,   8'd255, 8'd255, 8'd0,   8'd0,   8'd0};
    // adjacent sum of one: rounded mean minus one lands exactly at zero
    corner_px[5]  = '{8'd100, 8'd0,   8'd101, 8'd90,  8'd1,   8'd99,  8'd110};
    // all frames above cur
    corner_px[6]  = '{8'd10,  8'd200, 8'd12,  8'd11,  8'd210, 8'd15,  8'd30};
    // all frames below cur
    corner_px[7]  = '{8'd240, 8'd20,  8'd230, 8'd239, 8'd30,  8'd235, 8'd200};
    // outer frame equal to cur: zero difference bound
    corner_px[8]  = '{8'd50,  8'd255, 8'd50,  8'd40,  8'd255, 8'd60,  8'd55};
    corner_px[9]  = '{8'hAA,  8'h55,  8'h55,  8'h55,  8'hAA,  8'hAA,  8'hAA};
    corner_px[10] = '{8'h55,  8'hAA,  8'hAA,  8'hAA,  8'hAA,  8'hAA,  8'hAA};
    // far third frames only matter at strength 3
    corner_px[11] = '{8'd128, 8'd120, 8'd130, 8'd0,   8'd136, 8'd126, 8'd255};

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // writes to undecoded indexes must leave the reset settings alone
    write_register(CFG_SPARE_LO, 2'd3);
    write_register(CFG_SPARE_HI, 2'd3);
    cfg_valid <= 1'b0;

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      if (phase > 0) begin
        wait_drained();
        write_register(CFG_STRENGTH, PHASE_STRENGTH[phase]);
        write_register(CFG_AGGRESSIVE, PHASE_AGGRESSIVE[phase]);
        cfg_valid <= 1'b0;
      end
      burst_left = $urandom_range(0, 8);
      for (int k = 0; k < CORNERS_PER_SET; k++) begin
        offer_pixel(corner_px[(CORNERS_PER_SET * phase + k) % CORNERS], 1'b0);
        directed++;
      end
      for (int k = 0; k < RANDOM_PER_SET; k++)
        offer_pixel(random_pixel(), k == RANDOM_PER_SET - 1);
    end

    wait_drained();

    $display("%0d pixels (%0d corner cases) over %0d register settings,",
             pixels_accepted, directed, NUM_PHASES);
    $display("strength 0..3 in plain and aggressive mode: %0d results checked, %0d bad",
             sb.checked, sb.mismatches);
    failed = (sb.mismatches != 0) || (sb.pending() != 0);
    if (!failed)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
